@@ hw/rtl/circular_deque_assert.svh @@
// Assertion macros for the deque RTL, included by the controller.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// The consequent holds in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

@@ hw/rtl/cdq_pkg.sv @@
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF = 8;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/cdq_store.sv @@
`default_nettype none

module cdq_store #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire cdq_pkg::mem_ctl_t        mem_ctl,
  input  wire logic [$clog2(DEPTH)-1:0] mem_addr,
  input  wire logic signed [31:0]       mem_wdata,
  output logic signed [31:0]            mem_rdata
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_ctl.re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/cdq_idx.sv @@
`default_nettype none

module cdq_idx #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic [$clog2(DEPTH)-1:0] idx,
  input  wire logic                     up,
  output logic [$clog2(DEPTH)-1:0]      step
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);

  always_comb begin
    if (up) begin
      step = (idx == IDX_LAST) ? '0 : idx + IW'(1);
    end else begin
      step = (idx == '0) ? IDX_LAST : idx - IW'(1);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cdq_ctrl.sv @@
`default_nettype none

module cdq_ctrl #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire cdq_pkg::req_t            in_req,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output cdq_pkg::rsp_t                 out_rsp,
  output cdq_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(DEPTH)-1:0]      mem_addr,
  output logic signed [31:0]            mem_wdata,
  input  wire logic signed [31:0]       mem_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_OUT} state_t;

  state_t          state_r, state_nxt;
  cdq_pkg::req_t   req_r, req_nxt;
  cdq_pkg::rsp_t   rsp_r, rsp_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic [IW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   idx_in;
  logic            idx_up;
  logic [IW-1:0]   idx_step;
  logic            is_empty;
  logic            is_full;
  logic            front_op;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  assign front_op = (req_r.operation == cdq_pkg::OP_PUSH_FRONT) ||
                    (req_r.operation == cdq_pkg::OP_POP_FRONT);

  always_comb begin
    if (state_r == S_EXEC) begin
      idx_in = front_op ? head_r : tail_r;
      idx_up = (req_r.operation == cdq_pkg::OP_PUSH_REAR) ||
               (req_r.operation == cdq_pkg::OP_POP_FRONT);
    end else begin
      idx_in = ptr_r;
      idx_up = 1'b1;
    end
  end

  cdq_idx #(.DEPTH(DEPTH)) u_idx (
    .idx  (idx_in),
    .up   (idx_up),
    .step (idx_step)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    mem_ctl       = '0;
    mem_addr      = idx_step;
    mem_wdata     = req_r.value;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_r.operation) inside
          cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
            rsp_nxt.data  = req_r.value;
            rsp_nxt.last  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
            if (is_full) begin
              rsp_nxt.status = cdq_pkg::ST_FULL;
            end else begin
              rsp_nxt.status = cdq_pkg::ST_OK;
              mem_ctl.we     = 1'b1;
              count_nxt      = count_r + CW'(1);
              if (is_empty) begin
                head_nxt = '0;
                tail_nxt = '0;
                mem_addr = '0;
              end else if (front_op) begin
                head_nxt = idx_step;
              end else begin
                tail_nxt = idx_step;
              end
            end
          end
          cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
            if (is_empty) begin
              rsp_nxt.status = cdq_pkg::ST_EMPTY;
              rsp_nxt.data   = '0;
              rsp_nxt.last   = 1'b1;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_OUT;
            end else begin
              mem_ctl.re = 1'b1;
              mem_addr   = front_op ? head_r : tail_r;
              count_nxt  = count_r - CW'(1);
              state_nxt  = S_READ;
              if (count_r == CW'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else if (front_op) begin
                head_nxt = idx_step;
              end else begin
                tail_nxt = idx_step;
              end
            end
          end
          cdq_pkg::OP_DUMP: begin
            if (is_empty) begin
              rsp_nxt.status = cdq_pkg::ST_EMPTY;
              rsp_nxt.data   = '0;
              rsp_nxt.last   = 1'b1;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_OUT;
            end else begin
              mem_ctl.re = 1'b1;
              mem_addr   = head_r;
              ptr_nxt    = head_r;
              state_nxt  = S_READ;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        rsp_nxt.status = cdq_pkg::ST_OK;
        rsp_nxt.data   = mem_rdata;
        rsp_nxt.last   = (req_r.operation != cdq_pkg::OP_DUMP) || (ptr_r == tail_r);
        out_valid_nxt  = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (!rsp_r.last) begin
            ptr_nxt    = idx_step;
            mem_ctl.re = 1'b1;
            mem_addr   = idx_step;
            state_nxt  = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
    end
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
    ptr_r <= ptr_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

`include "circular_deque_assert.svh"

  `CDQ_ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `CDQ_ASSERT_SAME(a_empty_idx, clk, rst_n, count_r == '0, head_r == '0 && tail_r == '0)
  `CDQ_ASSERT_SAME(a_busy_out, clk, rst_n, out_valid_r, in_stall)
  `CDQ_ASSERT_NEXT(a_last_done, clk, rst_n, out_valid_r && !out_stall && rsp_r.last,
                   !out_valid_r && state_r == S_IDLE)

endmodule

`default_nettype wire

@@ hw/rtl/circular_deque.sv @@
// Push, full push and empty pop: the accepted request is executed, then its result is registered for output.
// Pop of an entry: execution issues a registered store read, whose data then goes to the output register.
// Dump of N entries: the entries go out one after another from head to tail, each of them
// going through the single store read port and the output register.
// Reset: indices and entry count clear to empty; store contents stay undefined, no clearing.
// A new request is accepted only in idle, after the last result is taken; an output stall delays that.
`default_nettype none

module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cdq_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cdq_pkg::rsp_t      out_rsp
);

  cdq_pkg::mem_ctl_t          mem_ctl;
  logic [$clog2(DEPTH)-1:0]   mem_addr;
  logic signed [31:0]         mem_wdata;
  logic signed [31:0]         mem_rdata;

  cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  cdq_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire
